/* rtl/hkrb_pkg.sv */
package hkrb_pkg;

   // Report geometry.
   localparam int KEY_SLOTS = 6;
   localparam int MAX_SLOTS = 6;
   localparam int SLOT_LIMIT = (KEY_SLOTS > MAX_SLOTS) ? MAX_SLOTS : KEY_SLOTS;
   localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);

   // Modifier usage code range.
   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam logic [7:0] MOD_LAST  = 8'hE7;

   // Request kinds.
   localparam logic REQ_KEY = 1'b0;
   localparam logic REQ_EOS = 1'b1;

   // Register map, word index of the APB address.
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_NO_KEY   = 2'd0;
   localparam logic [1:0] REG_TOGGLE   = 2'd1;
   localparam logic [1:0] REG_VOL_UP   = 2'd2;
   localparam logic [1:0] REG_VOL_DOWN = 2'd3;

   // Register reset values.
   localparam logic [7:0] NO_KEY_RST   = 8'd0;
   localparam logic [7:0] TOGGLE_RST   = 8'd240;
   localparam logic [7:0] VOL_UP_RST   = 8'd128;
   localparam logic [7:0] VOL_DOWN_RST = 8'd129;

   typedef struct packed {
      logic       req_type;
      logic [7:0] keycode;
      logic       encoder_a;
      logic       encoder_b;
   } req_item_type;

   typedef struct packed {
      logic [7:0] modifiers;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
      logic       report_changed;
      logic       leds_enabled;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] no_key_code;
      logic [7:0] led_toggle_code;
      logic [7:0] volume_up_code;
      logic [7:0] volume_down_code;
   } cfg_type;

   typedef logic [MAX_SLOTS-1:0][7:0] slot_array_type;

   // Keys gathered during the current scan.
   typedef struct packed {
      logic [7:0]     mods;
      slot_array_type slots;
      logic           toggle_seen;
   } scan_state_type;

endpackage

/* rtl/hkrb_csr.sv */
module hkrb_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hkrb_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output hkrb_pkg::cfg_type          cfg
);
   import hkrb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [7:0] rd_byte;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NO_KEY:   cfg_in.no_key_code      = pwdata[7:0];
            REG_TOGGLE:   cfg_in.led_toggle_code  = pwdata[7:0];
            REG_VOL_UP:   cfg_in.volume_up_code   = pwdata[7:0];
            REG_VOL_DOWN: cfg_in.volume_down_code = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.no_key_code      <= NO_KEY_RST;
         cfg_ff.led_toggle_code  <= TOGGLE_RST;
         cfg_ff.volume_up_code   <= VOL_UP_RST;
         cfg_ff.volume_down_code <= VOL_DOWN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_idx)
         REG_NO_KEY:   rd_byte = cfg_ff.no_key_code;
         REG_TOGGLE:   rd_byte = cfg_ff.led_toggle_code;
         REG_VOL_UP:   rd_byte = cfg_ff.volume_up_code;
         REG_VOL_DOWN: rd_byte = cfg_ff.volume_down_code;
         default:      rd_byte = 8'd0;
      endcase
   end

   assign prdata = {24'd0, rd_byte};
   assign cfg    = cfg_ff;

endmodule

/* rtl/hkrb_scan.sv */
module hkrb_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     key_load,
   input  logic                     scan_clear,
   input  logic [7:0]               keycode,
   input  hkrb_pkg::cfg_type        cfg,
   output hkrb_pkg::scan_state_type scan
);
   import hkrb_pkg::*;

   logic [7:0]            mods_ff, mods_in;
   slot_array_type        slots_ff, slots_in;
   logic [SLOT_CNT_W-1:0] count_ff, count_in;
   logic                  toggle_ff, toggle_in;
   logic                  is_toggle;
   logic                  is_empty;
   logic                  is_mod;
   logic                  has_room;

   assign is_toggle = (keycode == cfg.led_toggle_code);
   assign is_empty  = (keycode == cfg.no_key_code);
   assign is_mod    = (keycode >= MOD_FIRST) && (keycode <= MOD_LAST);
   assign has_room  = (count_ff < SLOT_CNT_W'(SLOT_LIMIT));

   // One key beat: toggle key, modifier bit, or next free slot; an end-of-scan beat clears the scan.
   always_comb begin
      mods_in   = mods_ff;
      slots_in  = slots_ff;
      count_in  = count_ff;
      toggle_in = toggle_ff;
      if (scan_clear) begin
         mods_in   = 8'd0;
         slots_in  = '0;
         count_in  = '0;
         toggle_in = 1'b0;
      end else if (key_load) begin
         if (is_toggle) begin
            toggle_in = 1'b1;
         end else if (!is_empty) begin
            if (is_mod) begin
               mods_in = mods_ff | (8'd1 << keycode[2:0]);
            end else if (has_room) begin
               for (int i = 0; i < MAX_SLOTS; i++) begin
                  if (count_ff == SLOT_CNT_W'(i)) begin
                     slots_in[i] = keycode;
                  end
               end
               count_in = count_ff + SLOT_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff   <= 8'd0;
         slots_ff  <= '0;
         count_ff  <= '0;
         toggle_ff <= 1'b0;
      end else begin
         mods_ff   <= mods_in;
         slots_ff  <= slots_in;
         count_ff  <= count_in;
         toggle_ff <= toggle_in;
      end
   end

   assign scan.mods        = mods_ff;
   assign scan.slots       = slots_ff;
   assign scan.toggle_seen = toggle_ff;

endmodule

/* rtl/hkrb_report.sv */
module hkrb_report (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     eos_load,
   input  logic                     encoder_a,
   input  logic                     encoder_b,
   input  hkrb_pkg::cfg_type        cfg,
   input  hkrb_pkg::scan_state_type scan,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output hkrb_pkg::rsp_item_type   rsp_payload
);
   import hkrb_pkg::*;

   logic           leds_ff, leds_in;
   logic           held_ff, held_in;
   logic           last_a_ff, last_a_in;
   logic [7:0]     prev_mods_ff;
   slot_array_type prev_slots_ff;
   slot_array_type rep_slots;
   logic           enc_edge;
   logic           changed;
   logic           valid_ff, valid_in;
   rsp_item_type   out_ff, out_in;

   // LED enable flips once per press of the toggle key.
   always_comb begin
      leds_in = leds_ff;
      if (scan.toggle_seen && !held_ff) begin
         leds_in = ~leds_ff;
      end
      held_in   = scan.toggle_seen;
      last_a_in = encoder_a;
   end

   // Slot bytes, with the volume code on a falling edge of line A.
   assign enc_edge = last_a_ff & ~encoder_a;
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         rep_slots[i] = (i < SLOT_LIMIT) ? scan.slots[i] : 8'd0;
      end
      if (enc_edge) begin
         rep_slots[0] = encoder_b ? cfg.volume_up_code : cfg.volume_down_code;
      end
   end

   // Only the modifiers and the slot bytes are compared with the previous report.
   assign changed = (scan.mods != prev_mods_ff) || (rep_slots != prev_slots_ff);

   always_comb begin
      out_in.modifiers      = scan.mods;
      out_in.key_slot_0     = rep_slots[0];
      out_in.key_slot_1     = rep_slots[1];
      out_in.key_slot_2     = rep_slots[2];
      out_in.key_slot_3     = rep_slots[3];
      out_in.key_slot_4     = rep_slots[4];
      out_in.key_slot_5     = rep_slots[5];
      out_in.report_changed = changed;
      out_in.leds_enabled   = leds_in;
   end

   // Result register: filled by an end-of-scan beat, emptied when taken.
   always_comb begin
      valid_in = valid_ff;
      if (eos_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leds_ff       <= 1'b1;
         held_ff       <= 1'b0;
         last_a_ff     <= 1'b1;
         prev_mods_ff  <= 8'd0;
         prev_slots_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (eos_load) begin
            leds_ff       <= leds_in;
            held_ff       <= held_in;
            last_a_ff     <= last_a_in;
            prev_mods_ff  <= scan.mods;
            prev_slots_ff <= rep_slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eos_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* rtl/hid_keyboard_report_builder.sv */
// An accepted key beat updates the scan state registers, and an accepted
// end-of-scan beat shows its report on the result port, in the next cycle.
// Throughput: one beat per cycle, held back only while an unread report
// sits in the result register and rsp_ready is low.
// Reset (synchronous, active high) clears the scan, LED enable on, line A
// taken as high, previous report zero, registers to their defaults.
module hid_keyboard_report_builder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  hkrb_pkg::req_item_type     req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output hkrb_pkg::rsp_item_type     rsp_payload,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hkrb_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import hkrb_pkg::*;

   cfg_type        cfg;
   scan_state_type scan;
   logic           req_fire;
   logic           key_load;
   logic           eos_load;

   // A beat is taken whenever the result register is free or being drained.
   assign req_ready = ~rsp_valid | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign key_load  = req_fire & (req_payload.req_type == REQ_KEY);
   assign eos_load  = req_fire & (req_payload.req_type == REQ_EOS);

   hkrb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hkrb_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .key_load   (key_load),
      .scan_clear (eos_load),
      .keycode    (req_payload.keycode),
      .cfg        (cfg),
      .scan       (scan)
   );

   hkrb_report u_report (
      .clock       (clock),
      .reset       (reset),
      .eos_load    (eos_load),
      .encoder_a   (req_payload.encoder_a),
      .encoder_b   (req_payload.encoder_b),
      .cfg         (cfg),
      .scan        (scan),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
